>>> design/tmsbc_pkg.sv
// Shared types, constants and helpers for the tile map swept box collision block.
package tmsbc_pkg;

   localparam int MapCols   = 64;
   localparam int MapRows   = 64;
   localparam int TileLog2  = 5;
   localparam int FracBits  = 8;
   localparam int TShift    = TileLog2 + FracBits;
   localparam int ColBits   = $clog2(MapCols);
   localparam int RowBits   = $clog2(MapRows);
   localparam int AddrBits  = ColBits + RowBits;
   localparam int PosBits   = 24;
   localparam int SizeBits  = 16;
   localparam int SumBits   = PosBits + 2;
   localparam int IdxBits   = SumBits - TShift + 1;
   localparam int ExtBits   = 7;
   localparam int KindBits  = 8;

   localparam logic [1:0] REQ_WRITE  = 2'd0;
   localparam logic [1:0] REQ_SWEEP  = 2'd1;
   localparam logic [1:0] REQ_GROUND = 2'd2;

   localparam logic [1:0] CSR_MAP_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_SOLID_TYPE  = 2'd2;
   localparam logic [1:0] CSR_BORDER_TYPE = 2'd3;

   localparam logic [ExtBits-1:0]  MAP_WIDTH_RESET   = 7'd64;
   localparam logic [ExtBits-1:0]  MAP_HEIGHT_RESET  = 7'd64;
   localparam logic [KindBits-1:0] SOLID_TYPE_RESET  = 8'd1;
   localparam logic [KindBits-1:0] BORDER_TYPE_RESET = 8'd1;

   typedef logic signed [IdxBits-1:0] idx_type;

   typedef struct packed {
      logic wr;
      logic load;
      logic step;
      logic scan_init;
      logic col_next;
      logic read;
      logic finish;
      logic hit;
   } ctl_cmd_type;

   typedef struct packed {
      logic same;
      logic line_hit;
      logic line_free;
      logic line_last;
      logic tile_hit;
      logic col_last;
   } dp_stat_type;

   function automatic idx_type tile_of(input logic signed [SumBits-1:0] v);
      logic signed [SumBits-1:0] s;
      s = v >>> TShift;
      tile_of = idx_type'(s);
   endfunction

endpackage

>>> design/tmsbc_ctrl.sv
// Controller state machine: sequences line checks, tile reads and result hand-off.
module tmsbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  tmsbc_pkg::dp_stat_type stat,
   output tmsbc_pkg::ctl_cmd_type cmd
);
   import tmsbc_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_LINE, S_READ, S_CHECK, S_FINISH} state_type;

   state_type state_ff, state_in;
   logic      hit_ff, hit_in;
   logic      valid_ff, valid_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      hit_in   = hit_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd      = '0;
      cmd.hit  = hit_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == REQ_WRITE) begin
                  cmd.wr = 1'b1;
               end else if (req_tuser == REQ_SWEEP || req_tuser == REQ_GROUND) begin
                  cmd.load = 1'b1;
                  state_in = S_LINE;
               end
            end
         end
         S_LINE: begin
            if (stat.same) begin
               hit_in   = 1'b0;
               state_in = S_FINISH;
            end else if (stat.line_hit) begin
               hit_in   = 1'b1;
               state_in = S_FINISH;
            end else if (stat.line_free) begin
               if (stat.line_last) begin
                  hit_in   = 1'b0;
                  state_in = S_FINISH;
               end else begin
                  cmd.step = 1'b1;
               end
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.tile_hit) begin
               hit_in   = 1'b1;
               state_in = S_FINISH;
            end else if (stat.col_last) begin
               if (stat.line_last) begin
                  hit_in   = 1'b0;
                  state_in = S_FINISH;
               end else begin
                  cmd.step = 1'b1;
                  state_in = S_LINE;
               end
            end else begin
               cmd.col_next = 1'b1;
               state_in     = S_READ;
            end
         end
         S_FINISH: begin
            if (!valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hit_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> design/tmsbc_dp.sv
// Datapath: tile store, configuration registers, line and tile checks, result register.
module tmsbc_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [1:0]                csr_index,
   input  logic [7:0]                csr_data,
   input  logic [1:0]                req_type,
   input  logic                      axis,
   input  logic signed [23:0]        pos_x,
   input  logic signed [23:0]        pos_y,
   input  logic signed [23:0]        target,
   input  logic [15:0]               box_w,
   input  logic [15:0]               box_h,
   input  logic [5:0]                tile_col,
   input  logic [5:0]                tile_row,
   input  logic [7:0]                tile_kind,
   input  tmsbc_pkg::ctl_cmd_type    cmd,
   output tmsbc_pkg::dp_stat_type    stat,
   output logic signed [23:0]        new_pos,
   output logic                      blocked,
   output logic                      grounded
);
   import tmsbc_pkg::*;

   logic [KindBits-1:0] mem [MapCols*MapRows];

   logic [ExtBits-1:0]  width_ff, height_ff;
   logic [KindBits-1:0] solid_ff, border_ff, rd_ff;

   idx_type line_ff, first_ff, last_ff, c0_ff, c1_ff;
   logic [ColBits-1:0]  c_ff, cend_ff;
   logic signed [PosBits-1:0] p_ff, tgt_ff;
   logic [SizeBits-1:0] size_ff;
   logic                dir_ff, vert_ff, ground_ff, same_ff;
   logic signed [PosBits-1:0] pos_ff;
   logic                blocked_ff, grounded_ff;

   // load-time operands
   logic signed [PosBits-1:0] p_sel, cross_sel;
   logic [SizeBits-1:0]       size_sel, csize_sel;
   logic                      vert_sel, dir_sel;
   logic signed [SumBits-1:0] p_w, tgt_w, cross_w, below_w;
   idx_type first_sel, last_sel, c0_sel, c1_sel;

   always_comb begin
      vert_sel  = axis || (req_type == REQ_GROUND);
      p_sel     = axis ? pos_y : pos_x;
      size_sel  = axis ? box_h : box_w;
      cross_sel = axis ? pos_x : pos_y;
      csize_sel = axis ? box_w : box_h;
      p_w       = SumBits'(p_sel);
      tgt_w     = SumBits'(target);
      dir_sel   = (target > p_sel);
      if (dir_sel) begin
         first_sel = tile_of(p_w + SumBits'({1'b0, size_sel}) - SumBits'(1));
         last_sel  = tile_of(tgt_w + SumBits'({1'b0, size_sel}) - SumBits'(1));
      end else begin
         first_sel = tile_of(p_w);
         last_sel  = tile_of(tgt_w);
      end
      cross_w = SumBits'(cross_sel);
      c0_sel  = tile_of(cross_w);
      c1_sel  = tile_of(cross_w + SumBits'({1'b0, csize_sel}) - SumBits'(1));
      if (req_type == REQ_GROUND) begin
         below_w   = SumBits'(pos_y) + SumBits'({1'b0, box_h});
         first_sel = tile_of(below_w);
         last_sel  = first_sel;
         c0_sel    = tile_of(SumBits'(pos_x));
         c1_sel    = tile_of(SumBits'(pos_x) + SumBits'({1'b0, box_w}) - SumBits'(1));
      end else begin
         below_w = '0;
      end
   end

   // line verdict
   logic [ExtBits-1:0] cols_used, rows_used, line_ext, cross_ext;
   idx_type line_lim, cross_lim, cs, ce;
   logic    border_solid, line_out, cross_out;

   always_comb begin
      cols_used    = (width_ff < ExtBits'(MapCols)) ? width_ff : ExtBits'(MapCols);
      rows_used    = (height_ff < ExtBits'(MapRows)) ? height_ff : ExtBits'(MapRows);
      line_ext     = vert_ff ? rows_used : cols_used;
      cross_ext    = vert_ff ? cols_used : rows_used;
      line_lim     = idx_type'({1'b0, line_ext});
      cross_lim    = idx_type'({1'b0, cross_ext});
      border_solid = (border_ff == solid_ff);
      line_out     = (line_ff < 0) || (line_ff >= line_lim);
      cross_out    = (c0_ff < 0) || (c1_ff >= cross_lim);
      cs           = (c0_ff < 0) ? '0 : c0_ff;
      ce           = (c1_ff > cross_lim - idx_type'(1)) ? cross_lim - idx_type'(1) : c1_ff;
      stat.same      = same_ff;
      stat.line_last = (line_ff == last_ff);
      stat.line_hit  = 1'b0;
      stat.line_free = 1'b0;
      if (c1_ff < c0_ff) begin
         stat.line_free = 1'b1;
      end else if (line_out) begin
         stat.line_hit  = border_solid;
         stat.line_free = !border_solid;
      end else if (cross_out && border_solid) begin
         stat.line_hit = 1'b1;
      end else if (ce < cs) begin
         stat.line_free = 1'b1;
      end
      stat.tile_hit = (rd_ff == solid_ff);
      stat.col_last = (c_ff == cend_ff);
   end

   logic [ColBits-1:0] line_col;
   logic [RowBits-1:0] line_row;
   logic [AddrBits-1:0] rd_addr;
   always_comb begin
      line_col = ColBits'(line_ff);
      line_row = RowBits'(line_ff);
      rd_addr  = vert_ff ? {line_row, RowBits'(c_ff)} : {RowBits'(c_ff), line_col};
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[{tile_row, tile_col}] <= tile_kind;
      end
      if (cmd.read) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= MAP_WIDTH_RESET;
         height_ff <= MAP_HEIGHT_RESET;
         solid_ff  <= SOLID_TYPE_RESET;
         border_ff <= BORDER_TYPE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAP_WIDTH:   width_ff  <= ExtBits'(csr_data);
            CSR_MAP_HEIGHT:  height_ff <= ExtBits'(csr_data);
            CSR_SOLID_TYPE:  solid_ff  <= csr_data;
            CSR_BORDER_TYPE: border_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // blocked position
   logic signed [SumBits+1:0] line_pix, stop_pos;
   always_comb begin
      line_pix = (SumBits+2)'(line_ff) <<< TShift;
      if (line_ff == first_ff)
         stop_pos = (SumBits+2)'(p_ff);
      else if (dir_ff)
         stop_pos = line_pix - (SumBits+2)'({1'b0, size_ff});
      else
         stop_pos = line_pix + ((SumBits+2)'(1) <<< TShift);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         line_ff   <= first_sel;
         first_ff  <= first_sel;
         last_ff   <= last_sel;
         c0_ff     <= c0_sel;
         c1_ff     <= c1_sel;
         p_ff      <= p_sel;
         tgt_ff    <= target;
         size_ff   <= size_sel;
         dir_ff    <= dir_sel;
         vert_ff   <= vert_sel;
         ground_ff <= (req_type == REQ_GROUND);
         same_ff   <= (req_type != REQ_GROUND) && (target == p_sel);
      end
      if (cmd.step) begin
         line_ff <= dir_ff ? line_ff + idx_type'(1) : line_ff - idx_type'(1);
      end
      if (cmd.scan_init) begin
         c_ff    <= ColBits'(cs);
         cend_ff <= ColBits'(ce);
      end
      if (cmd.col_next) begin
         c_ff <= c_ff + ColBits'(1);
      end
      if (cmd.finish) begin
         if (ground_ff) begin
            pos_ff      <= '0;
            blocked_ff  <= 1'b0;
            grounded_ff <= cmd.hit;
         end else begin
            pos_ff      <= cmd.hit ? PosBits'(stop_pos) : tgt_ff;
            blocked_ff  <= cmd.hit;
            grounded_ff <= 1'b0;
         end
      end
   end

   assign new_pos  = pos_ff;
   assign blocked  = blocked_ff;
   assign grounded = grounded_ff;

endmodule

>>> design/tile_map_swept_box_collision.sv
// Top level of the tile map swept box collision block.
// A write beat stores one tile type byte. A sweep or ground test accepts the beat, takes
// the verdict of every line it visits, reads and checks each tile in turn (registered read
// of the single-port tile store, then compare) for lines scanned inside the map, and then
// loads the result register. The result sits in an output register, so the next request
// is taken while it waits; a finished item holds until that register is free.
module tile_map_swept_box_collision (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // req_type
   // axis, pos_x, pos_y, target, box_w, box_h, tile_col, tile_row, tile_kind, pad
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // new_pos, blocked, grounded, pad
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_data
);
   import tmsbc_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;
   logic signed [23:0] new_pos;
   logic blocked, grounded;

   assign csr_ready = 1'b1;

   tmsbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tmsbc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_type  (req_tuser),
      .axis      (req_tdata[0]),
      .pos_x     (req_tdata[24:1]),
      .pos_y     (req_tdata[48:25]),
      .target    (req_tdata[72:49]),
      .box_w     (req_tdata[88:73]),
      .box_h     (req_tdata[104:89]),
      .tile_col  (req_tdata[110:105]),
      .tile_row  (req_tdata[116:111]),
      .tile_kind (req_tdata[124:117]),
      .cmd       (cmd),
      .stat      (stat),
      .new_pos   (new_pos),
      .blocked   (blocked),
      .grounded  (grounded)
   );

   assign rsp_tdata = {6'd0, grounded, blocked, new_pos};

endmodule

>>> sim/tb_tile_map_swept_box_collision.sv
// Self-checking testbench for the tile map swept box collision block.
`timescale 1ns / 100ps

module tb_tile_map_swept_box_collision;
   import tmsbc_pkg::*;

   typedef struct {
      logic [1:0]  kind_of_req;
      logic        axis;
      logic [23:0] px;
      logic [23:0] py;
      logic [23:0] tgt;
      logic [15:0] bw;
      logic [15:0] bh;
      logic [5:0]  col;
      logic [5:0]  row;
      logic [7:0]  kind;
   } beat_type;

   typedef struct {
      logic [23:0] new_pos;
      logic        blocked;
      logic        grounded;
   } outcome_type;

   typedef struct {
      beat_type    b;
      bit          typed;
      bit          has_rsp;
      outcome_type o;
   } dir_row_type;

   localparam longint TileLsb = 64'sd1 <<< TShift;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [31:0]  rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [7:0]   csr_data = '0;

   logic [7:0]  tiles [MapRows*MapCols];
   logic [6:0]  map_w, map_h;
   logic [7:0]  solid_k, border_k;
   outcome_type pending [$];
   int          errors = 0;
   int          tx_idle = 0;
   int          rx_idle = 0;
   dir_row_type dir_tab [$];

   tile_map_swept_box_collision uut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rx_idle);

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = pending.pop_front();
            if (rsp_tdata[23:0] !== e.new_pos || rsp_tdata[24] !== e.blocked ||
                rsp_tdata[25] !== e.grounded) begin
               $display("%0t: expected pos %h blk %b gnd %b, got pos %h blk %b gnd %b",
                        $time, e.new_pos, e.blocked, e.grounded,
                        rsp_tdata[23:0], rsp_tdata[24], rsp_tdata[25]);
               errors++;
            end
         end
      end
   end

   function automatic longint tile_idx(longint v);
      return v >>> TShift;
   endfunction

   function automatic bit line_solid(bit vert, longint line, longint c0, longint c1);
      longint line_ext, cross_ext;
      bit     bsolid;
      line_ext  = vert ? ((map_h < MapRows) ? map_h : MapRows) : ((map_w < MapCols) ? map_w : MapCols);
      cross_ext = vert ? ((map_w < MapCols) ? map_w : MapCols) : ((map_h < MapRows) ? map_h : MapRows);
      bsolid = (border_k == solid_k);
      if (c1 < c0) return 0;
      if (line < 0 || line >= line_ext) return bsolid;
      if ((c0 < 0 || c1 >= cross_ext) && bsolid) return 1;
      if (c0 < 0) c0 = 0;
      if (c1 > cross_ext - 1) c1 = cross_ext - 1;
      for (longint c = c0; c <= c1; c++) begin
         if (vert ? tiles[line*MapCols + c] == solid_k : tiles[c*MapCols + line] == solid_k)
            return 1;
      end
      return 0;
   endfunction

   function automatic longint sweep_to(bit vert, longint p, longint sz, longint tgt,
                                       longint cr, longint csz, output bit blk);
      longint c0, c1, pos, first, last;
      c0 = tile_idx(cr);
      c1 = tile_idx(cr + csz - 1);
      pos = p;
      blk = 0;
      if (tgt > p) begin
         first = tile_idx(p + sz - 1);
         last  = tile_idx(tgt + sz - 1);
         for (longint i = first; i <= last; i++) begin
            if (line_solid(vert, i, c0, c1)) begin
               blk = 1;
               return pos;
            end
            pos = (i == last) ? tgt : (i + 1) * TileLsb - sz;
         end
      end else if (tgt < p) begin
         first = tile_idx(p);
         last  = tile_idx(tgt);
         for (longint i = first; i >= last; i--) begin
            if (line_solid(vert, i, c0, c1)) begin
               blk = 1;
               return pos;
            end
            pos = (i == last) ? tgt : i * TileLsb;
         end
      end
      return pos;
   endfunction

   function automatic bit collide(beat_type b, output outcome_type o);
      longint px, py, tgt, bw, bh;
      bit     blk;
      px = $signed(b.px);
      py = $signed(b.py);
      tgt = $signed(b.tgt);
      bw = b.bw;
      bh = b.bh;
      o = '{default: '0};
      case (b.kind_of_req)
         REQ_WRITE: begin
            tiles[b.row*MapCols + b.col] = b.kind;
            return 0;
         end
         REQ_SWEEP: begin
            o.new_pos = b.axis ? 24'(sweep_to(1, py, bh, tgt, px, bw, blk))
                               : 24'(sweep_to(0, px, bw, tgt, py, bh, blk));
            o.blocked = blk;
            return 1;
         end
         REQ_GROUND: begin
            o.grounded = line_solid(1, tile_idx(py + bh), tile_idx(px), tile_idx(px + bw - 1));
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   task automatic send(beat_type b, bit typed = 0, bit has_rsp = 0,
                       outcome_type o_typed = '{default: '0});
      outcome_type o;
      bit          r;
      int          gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle) gap++;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= b.kind_of_req;
      req_tdata  <= {3'b0, b.kind, b.row, b.col, b.bh, b.bw, b.tgt, b.py, b.px, b.axis};
      do @(posedge clock); while (!req_tready);
      r = collide(b, o);
      if (typed) begin
         r = has_rsp;
         o = o_typed;
      end
      if (r) pending.push_back(o);
   endtask

   task automatic settle();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_MAP_WIDTH:  map_w = val[6:0];
         CSR_MAP_HEIGHT: map_h = val[6:0];
         CSR_SOLID_TYPE: solid_k = val;
         default:        border_k = val;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_kind();
      case ($urandom_range(5))
         0: return 8'd1;
         1: return 8'd3;
         2: return 8'd7;
         3: return 8'd255;
         4: return 8'd0;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] near_coord();
      return 24'(int'($urandom_range(0, 69*8192)) - 2*8192);
   endfunction

   function automatic beat_type random_beat();
      beat_type b;
      int       sel;
      b.kind_of_req = REQ_SWEEP;
      b.axis = 1'($urandom_range(1));
      b.px = near_coord();
      b.py = near_coord();
      b.bw = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(24576));
      b.bh = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(24576));
      b.tgt = (b.axis ? b.py : b.px) + 24'(int'($urandom_range(12*8192)) - 6*8192);
      b.col = 6'($urandom);
      b.row = 6'($urandom);
      b.kind = pick_kind();
      sel = $urandom_range(99);
      if (sel < 20) b.kind_of_req = REQ_WRITE;
      else if (sel < 45) b.kind_of_req = REQ_GROUND;
      else if (sel < 50) b.kind_of_req = 2'd3;
      else if (sel < 55) begin
         b.kind_of_req = 2'($urandom_range(1, 2));
         b.px = 24'($urandom);
         b.py = 24'($urandom);
         b.tgt = 24'($urandom);
         b.bw = 16'($urandom);
         b.bh = 16'($urandom);
      end else if (sel < 60) b.tgt = b.axis ? b.py : b.px;
      return b;
   endfunction

   function automatic beat_type mk(logic [1:0] rq, logic ax, int px, int py, int tg,
                                   int bw, int bh);
      beat_type b;
      b = '{kind_of_req: rq, axis: ax, px: 24'(px), py: 24'(py), tgt: 24'(tg),
            bw: 16'(bw), bh: 16'(bh), col: '0, row: '0, kind: '0};
      return b;
   endfunction

   task automatic add(beat_type b, bit typed = 0, bit has_rsp = 0,
                      outcome_type o = '{default: '0});
      dir_row_type d;
      d = '{b: b, typed: typed, has_rsp: has_rsp, o: o};
      dir_tab.push_back(d);
   endtask

   initial begin
      beat_type b;
      map_w = MAP_WIDTH_RESET;
      map_h = MAP_HEIGHT_RESET;
      solid_k = SOLID_TYPE_RESET;
      border_k = BORDER_TYPE_RESET;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int i = 0; i < MapRows*MapCols; i++) begin
         b = mk(REQ_WRITE, 0, 0, 0, 0, 0, 0);
         b.col = 6'(i % MapCols);
         b.row = 6'(i / MapCols);
         b.kind = 8'd0;
         send(b);
      end
      settle();

      add(mk(REQ_SWEEP, 0, 5000, 300, 5000, 256, 256), 1, 1, '{24'd5000, 1'b0, 1'b0});
      add(mk(REQ_SWEEP, 1, 300, 7000, 7000, 256, 256), 1, 1, '{24'd7000, 1'b0, 1'b0});
      add(mk(REQ_SWEEP, 0, 25600, 0, -10000, 256, 256), 1, 1, '{24'd0, 1'b1, 1'b0});
      add(mk(REQ_GROUND, 0, 0, 64*8192, 0, 256, 256), 1, 1, '{24'd0, 1'b0, 1'b1});
      add(mk(2'd3, 1, -1, -1, -1, 65535, 65535), 1, 0);
      b = mk(REQ_WRITE, 1, 0, 0, 0, 0, 0);
      b.col = 6'd63; b.row = 6'd63; b.kind = 8'd255;
      add(b);
      b.col = 6'd5; b.row = 6'd2; b.kind = 8'd1;
      add(b);
      add(mk(REQ_SWEEP, 0, 0, 2*8192, 20*8192, 8192, 8192));
      add(mk(REQ_SWEEP, 0, 20*8192, 2*8192, 0, 8192, 8192));
      add(mk(REQ_SWEEP, 1, 5*8192, 0, 10*8192, 0, 0));
      add(mk(REQ_SWEEP, 1, 5*8192, 10*8192, 0, 4096, 65535));
      add(mk(REQ_GROUND, 0, 5*8192, 8192, 0, 100, 8192));
      add(mk(REQ_GROUND, 0, 5*8192, 8192, 0, 0, 0));
      add(mk(REQ_SWEEP, 0, 8388607, 100, -8388608, 65535, 0));
      add(mk(REQ_SWEEP, 1, -8388608, -8388608, 8388607, 0, 65535));
      add(mk(REQ_GROUND, 0, 8388607, -8388608, 0, 65535, 65535));
      add(mk(REQ_SWEEP, 0, 63*8192, 63*8192, 70*8192, 8192, 8192));
      add(mk(REQ_SWEEP, 1, 63*8192, 60*8192, 63*8192, 8192, 8192));
      foreach (dir_tab[i]) send(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].has_rsp, dir_tab[i].o);
      settle();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: begin csr_write(CSR_MAP_WIDTH, 8'd1); csr_write(CSR_MAP_HEIGHT, 8'd1);
                  csr_write(CSR_SOLID_TYPE, 8'd0); csr_write(CSR_BORDER_TYPE, 8'd255); end
            2: begin csr_write(CSR_MAP_WIDTH, 8'd0); csr_write(CSR_MAP_HEIGHT, 8'd0);
                  csr_write(CSR_SOLID_TYPE, 8'd7); csr_write(CSR_BORDER_TYPE, 8'd7); end
            3: begin csr_write(CSR_MAP_WIDTH, 8'd127); csr_write(CSR_MAP_HEIGHT, 8'd127);
                  csr_write(CSR_SOLID_TYPE, 8'd255); csr_write(CSR_BORDER_TYPE, 8'd0); end
            4: begin csr_write(CSR_MAP_WIDTH, 8'd40); csr_write(CSR_MAP_HEIGHT, 8'd20);
                  csr_write(CSR_SOLID_TYPE, 8'd3); csr_write(CSR_BORDER_TYPE, 8'd3); end
            default: ;
         endcase
         for (int n = 0; n < 130; n++) begin
            int k;
            k = ph * 130 + n;
            if (k < 217) begin tx_idle = 32; rx_idle = 46; end
            else if (k < 434) begin tx_idle = 46; rx_idle = 32; end
            else begin tx_idle = 0; rx_idle = 0; end
            if (n == 65) settle();
            send(random_beat());
         end
         settle();
      end

      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #100000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
